// ----- rtl/statement_end_scanner_defines.svh -----
// Assertion macros shared by the statement end scanner RTL.
`ifndef STATEMENT_END_SCANNER_DEFINES_SVH
`define STATEMENT_END_SCANNER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger.
`define SES_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

// ----- rtl/ses_pkg.sv -----
// Package with constants, types and helpers of the statement end scanner.
`timescale 1ns / 1ps
package ses_pkg;

  localparam int MAX_LEN   = 512;
  localparam int LEN_LIMIT = ((MAX_LEN - 1) < 499) ? (MAX_LEN - 1) : 499;

  localparam int LEN_W   = 10;
  localparam int DEPTH_W = 11;

  localparam logic [LEN_W-1:0]           LEN_SAT   = '1;
  localparam logic signed [DEPTH_W-1:0]  DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic signed [DEPTH_W-1:0]  DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
  localparam logic [LEN_W:0]             LEN_LIMIT_V = (LEN_W+1)'(LEN_LIMIT);

  // Action codes.
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_CHAR  = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_SEMI   = 8'd59;
  localparam logic [7:0] CH_EQUAL  = 8'd61;
  localparam logic [7:0] CH_AMP    = 8'd38;
  localparam logic [7:0] CH_BAR    = 8'd124;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'd125;

  // One result word.
  typedef struct packed {
    logic       keep_valid;
    logic [7:0] kept_char;
    logic       stmt_end;
    logic       push_back;
    logic       err_left_paren;
    logic       err_too_long;
    logic       err_right_paren;
  } ses_result_t;

  // True when a newline after this last non-blank character continues the statement.
  function automatic logic continues_line(input logic [7:0] c);
    continues_line = (c == CH_NL)    || (c == CH_PLUS)   || (c == CH_MINUS) ||
                     (c == CH_STAR)  || (c == CH_LPAREN) || (c == CH_SLASH) ||
                     (c == CH_COMMA) || (c == CH_AMP)    || (c == CH_BAR)   ||
                     (c == CH_EQUAL);
  endfunction

endpackage

// ----- rtl/statement_end_scanner.sv -----
// Top level of the statement end scanner: scan state, output register and skid stage.
`timescale 1ns / 1ps
`include "statement_end_scanner_defines.svh"
// Usage
// The input channel (in_valid, in_stall, in_action, in_seed_char, in_src_char)
// carries one word per statement event. A word with action "begin" opens a fresh
// statement and seeds the last non-blank character; a word with action "char"
// delivers the next source character. Every accepted input word yields exactly
// one result word on the output channel (out_valid, out_stall and the result
// fields), which says whether the character is kept, whether it ends the
// statement, whether it goes back to the lexer, and the error flags.
// The result of an accepted word is registered: it is shown from the next cycle
// on if the output register is free and the skid register empty, else it waits
// in the skid register. One word is taken per cycle while in_stall is low; the
// scan state (quote mode, depth, last non-blank character, length) is updated
// by one level of compares and small counters at the edge that accepts a word.
// When the receiver stalls, the held result stays on the outputs and one more word
// goes into the skid register; in_stall rises only while the skid register is full.
// Reset (rst_n low at a clock edge) closes any statement, clears quote mode,
// depth and length, sets the last non-blank character to newline and empties
// both the output and the skid register.
module statement_end_scanner
  import ses_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_seed_char,
  input  logic [7:0] in_src_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_keep_valid,
  output logic [7:0] out_kept_char,
  output logic       out_stmt_end,
  output logic       out_push_back,
  output logic       out_err_left_paren,
  output logic       out_err_too_long,
  output logic       out_err_right_paren
);

  // Scan state.
  logic                      active_r,        active_nxt;
  logic                      in_quote_r,      in_quote_nxt;
  logic [7:0]                quote_mark_r,    quote_mark_nxt;
  logic [7:0]                last_nonblank_r, last_nonblank_nxt;
  logic signed [DEPTH_W-1:0] paren_depth_r,   paren_depth_nxt;
  logic [LEN_W-1:0]          text_length_r,   text_length_nxt;

  // Output register and skid register.
  logic        out_valid_r, out_valid_nxt;
  ses_result_t out_data_r,  out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  ses_result_t skid_data_r,  skid_data_nxt;

  ses_result_t res;
  logic        in_fire;
  logic        out_fire;
  logic        len_hit;
  logic [LEN_W-1:0] len_inc;
  logic signed [DEPTH_W-1:0] depth_dec;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  // Saturating length increment, and the limit check on the grown length.
  assign len_inc   = (text_length_r == LEN_SAT) ? text_length_r : text_length_r + 1'b1;
  assign len_hit   = ({1'b0, text_length_r} + 1'b1) >= LEN_LIMIT_V;
  assign depth_dec = (paren_depth_r == DEPTH_MIN) ? paren_depth_r : paren_depth_r - 1'b1;

  // Result and next scan state for the word at the input.
  always_comb begin
    logic ends;
    res               = '0;
    ends              = 1'b0;
    active_nxt        = active_r;
    in_quote_nxt      = in_quote_r;
    quote_mark_nxt    = quote_mark_r;
    last_nonblank_nxt = last_nonblank_r;
    paren_depth_nxt   = paren_depth_r;
    text_length_nxt   = text_length_r;

    if (in_action == ACT_BEGIN) begin
      // A begin word abandons any open statement and starts a clean one.
      active_nxt        = 1'b1;
      in_quote_nxt      = 1'b0;
      quote_mark_nxt    = '0;
      last_nonblank_nxt = in_seed_char;
      paren_depth_nxt   = '0;
      text_length_nxt   = '0;
    end else if (active_r) begin
      if (in_quote_r) begin
        // Inside quotes everything is text; only the matching mark matters.
        text_length_nxt = len_inc;
        res.keep_valid  = 1'b1;
        if (in_src_char == quote_mark_r) begin
          in_quote_nxt = 1'b0;
        end
      end else if (in_src_char == CH_SEMI) begin
        ends = 1'b1;
      end else if (in_src_char == CH_LBRACE || in_src_char == CH_RBRACE) begin
        ends          = 1'b1;
        res.push_back = 1'b1;
      end else if (in_src_char == CH_NL) begin
        // A newline after an operator, comma, open paren or newline continues the statement.
        if (continues_line(last_nonblank_r)) begin
          text_length_nxt = len_inc;
          res.keep_valid  = 1'b1;
        end else begin
          ends = 1'b1;
        end
      end else if (len_hit) begin
        ends             = 1'b1;
        res.push_back    = 1'b1;
        res.err_too_long = 1'b1;
      end else begin
        text_length_nxt = len_inc;
        res.keep_valid  = 1'b1;
        if (in_src_char != CH_SPACE && in_src_char != CH_TAB) begin
          last_nonblank_nxt = in_src_char;
        end
        if (in_src_char == CH_SQUOTE || in_src_char == CH_DQUOTE) begin
          in_quote_nxt   = 1'b1;
          quote_mark_nxt = in_src_char;
        end else if (in_src_char == CH_LPAREN) begin
          if (paren_depth_r != DEPTH_MAX) begin
            paren_depth_nxt = paren_depth_r + 1'b1;
          end
        end else if (in_src_char == CH_RPAREN) begin
          paren_depth_nxt    = depth_dec;
          res.err_left_paren = depth_dec[DEPTH_W-1];
        end
      end

      if (ends) begin
        res.stmt_end        = 1'b1;
        res.err_right_paren = !paren_depth_r[DEPTH_W-1] && (paren_depth_r != '0);
        active_nxt          = 1'b0;
        in_quote_nxt        = 1'b0;
      end
      if (res.keep_valid) begin
        res.kept_char = in_src_char;
      end
    end
  end

  // Output register and skid register: the output register refills from the
  // skid register first, then from the input.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = in_fire;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = in_fire;
        out_data_nxt  = res;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r        <= 1'b0;
      in_quote_r      <= 1'b0;
      quote_mark_r    <= '0;
      last_nonblank_r <= CH_NL;
      paren_depth_r   <= '0;
      text_length_r   <= '0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        active_r        <= active_nxt;
        in_quote_r      <= in_quote_nxt;
        quote_mark_r    <= quote_mark_nxt;
        last_nonblank_r <= last_nonblank_nxt;
        paren_depth_r   <= paren_depth_nxt;
        text_length_r   <= text_length_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_keep_valid      = out_data_r.keep_valid;
  assign out_kept_char       = out_data_r.kept_char;
  assign out_stmt_end        = out_data_r.stmt_end;
  assign out_push_back       = out_data_r.push_back;
  assign out_err_left_paren  = out_data_r.err_left_paren;
  assign out_err_too_long    = out_data_r.err_too_long;
  assign out_err_right_paren = out_data_r.err_right_paren;

  // The skid register only fills behind a held output word.
  `SES_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid word without output word")
  // A word is either kept or ends the statement, never both.
  `SES_ASSERT(a_keep_xor_end, !out_valid_r || !(out_keep_valid && out_stmt_end), "kept and ended")
  // Push back and the length error only come with a statement end.
  `SES_ASSERT(a_push_needs_end, !out_valid_r || !(out_push_back || out_err_too_long) || out_stmt_end,
              "push back without end")
  // Quote mode never survives a statement end.
  `SES_ASSERT_NEXT(a_end_closes, in_fire && res.stmt_end, !active_r && !in_quote_r,
                   "statement still open after end")
  // Quote mode is only ever set inside an open statement.
  `SES_ASSERT(a_quote_in_stmt, !in_quote_r || active_r, "quote mode outside a statement")

endmodule

// ----- dv/tb_statement_end_scanner.sv -----
// Self-checking testbench for the statement end scanner: stimulus, predictor and checks.
`timescale 1ns / 1ps
module tb_statement_end_scanner;
  import ses_pkg::*;

  // This limit only trips when the block hangs or stops handing back
  // result words.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 80;
  localparam int PRINT_CAP    = 200;

  // One input word as the sender holds it before it is offered.
  typedef struct packed {
    logic       action;
    logic [7:0] seed;
    logic [7:0] src;
  } scan_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_action = ACT_BEGIN;
  logic [7:0] in_seed_char = 8'd0;
  logic [7:0] in_src_char = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_keep_valid;
  logic [7:0] out_kept_char;
  logic       out_stmt_end;
  logic       out_push_back;
  logic       out_err_left_paren;
  logic       out_err_too_long;
  logic       out_err_right_paren;

  statement_end_scanner u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_seed_char        (in_seed_char),
    .in_src_char         (in_src_char),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_keep_valid      (out_keep_valid),
    .out_kept_char       (out_kept_char),
    .out_stmt_end        (out_stmt_end),
    .out_push_back       (out_push_back),
    .out_err_left_paren  (out_err_left_paren),
    .out_err_too_long    (out_err_too_long),
    .out_err_right_paren (out_err_right_paren)
  );

  // Words waiting to be offered, and the result words that accepted input
  // words have promised but the block has not yet handed over.
  scan_word_t  words_pending[$];
  ses_result_t results_due[$];

  int   n_words = 0;   // total words in the stimulus
  int   n_sent = 0;    // words put on the input ports so far
  int   n_taken = 0;   // words the block has accepted
  int   n_bad = 0;     // mismatches seen
  int   n_cycles = 0;
  logic in_taken = 1'b0;  // the word on the input ports was accepted at the last edge

  // Receiver hold-off: one long stall while the sender keeps offering words.
  int   hold_left = 0;
  logic hold_done = 1'b0;

  // Scanner state as the predictor sees it.
  logic                      sc_open;
  logic                      sc_quoted;
  logic [7:0]                sc_quote_ch;
  logic [7:0]                sc_last_nb;
  logic signed [DEPTH_W-1:0] sc_depth;
  logic [LEN_W-1:0]          sc_len;

  initial begin
    forever #4 clk = ~clk;
  end

  // A newline after one of these characters carries the statement on to the next line.
  function automatic logic line_goes_on(input logic [7:0] c);
    return c inside {CH_NL, CH_PLUS, CH_MINUS, CH_STAR, CH_LPAREN, CH_SLASH,
                     CH_COMMA, CH_AMP, CH_BAR, CH_EQUAL};
  endfunction

  // Text length saturates rather than wrapping, which matters inside long quotes.
  function automatic void grow_len();
    if (sc_len != LEN_SAT) sc_len = sc_len + 1'b1;
  endfunction

  // Advances the scanner state by one accepted word and returns the result
  // word it must produce.
  function automatic ses_result_t scan_step(input scan_word_t w);
    ses_result_t r;
    logic        ends;
    r = '0;
    ends = 1'b0;
    if (w.action == ACT_BEGIN) begin
      // A begin opens a fresh statement, dropping any statement still open.
      sc_open     = 1'b1;
      sc_quoted   = 1'b0;
      sc_quote_ch = 8'd0;
      sc_last_nb  = w.seed;
      sc_depth    = '0;
      sc_len      = '0;
    end else if (sc_open) begin
      if (sc_quoted) begin
        // Quoted text is kept verbatim, terminators included, with no length check.
        grow_len();
        r.keep_valid = 1'b1;
        if (w.src == sc_quote_ch) sc_quoted = 1'b0;
      end else if (w.src == CH_SEMI) begin
        ends = 1'b1;
      end else if (w.src == CH_LBRACE || w.src == CH_RBRACE) begin
        ends = 1'b1;
        r.push_back = 1'b1;
      end else if (w.src == CH_NL) begin
        if (line_goes_on(sc_last_nb)) begin
          grow_len();
          r.keep_valid = 1'b1;
        end else begin
          ends = 1'b1;
        end
      end else if (int'(sc_len) + 1 >= LEN_LIMIT) begin
        ends = 1'b1;
        r.push_back = 1'b1;
        r.err_too_long = 1'b1;
      end else begin
        grow_len();
        r.keep_valid = 1'b1;
        if (w.src != CH_SPACE && w.src != CH_TAB) sc_last_nb = w.src;
        if (w.src == CH_SQUOTE || w.src == CH_DQUOTE) begin
          sc_quoted   = 1'b1;
          sc_quote_ch = w.src;
        end else if (w.src == CH_LPAREN) begin
          if (sc_depth != DEPTH_MAX) sc_depth = sc_depth + 1'b1;
        end else if (w.src == CH_RPAREN) begin
          if (sc_depth != DEPTH_MIN) sc_depth = sc_depth - 1'b1;
          if (sc_depth < 0) r.err_left_paren = 1'b1;
        end
      end
      if (ends) begin
        r.stmt_end = 1'b1;
        r.err_right_paren = (sc_depth > 0);
        sc_open   = 1'b0;
        sc_quoted = 1'b0;
      end
      if (r.keep_valid) r.kept_char = w.src;
    end
    return r;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic note_mismatch(input string what, input int got, input int want);
    if (n_bad < PRINT_CAP)
      $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
    n_bad++;
  endtask

  task automatic put_word(input logic act, input logic [7:0] seed, input logic [7:0] src);
    scan_word_t w;
    w.action = act;
    w.seed   = seed;
    w.src    = src;
    words_pending.push_back(w);
  endtask

  // The unused field of each word gets random bits so that every bit toggles.
  task automatic put_begin(input logic [7:0] seed);
    put_word(ACT_BEGIN, seed, 8'($urandom));
  endtask

  task automatic put_char(input logic [7:0] c);
    put_word(ACT_CHAR, 8'($urandom), c);
  endtask

  function automatic logic [7:0] pick_goes_on();
    case ($urandom_range(0, 9))
      0:       return CH_NL;
      1:       return CH_PLUS;
      2:       return CH_MINUS;
      3:       return CH_STAR;
      4:       return CH_LPAREN;
      5:       return CH_SLASH;
      6:       return CH_COMMA;
      7:       return CH_AMP;
      8:       return CH_BAR;
      default: return CH_EQUAL;
    endcase
  endfunction

  // Body text of a random statement: letters, blanks, parens, quotes, operators
  // and newlines, with the odd arbitrary byte mixed in.
  function automatic logic [7:0] pick_text_char();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return 8'($urandom_range(97, 122));
      6, 7:             return CH_SPACE;
      8:                return CH_TAB;
      9, 10:            return CH_LPAREN;
      11, 12:           return CH_RPAREN;
      13:               return $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      14, 15:           return pick_goes_on();
      16, 17:           return CH_NL;
      default:          return 8'($urandom);
    endcase
  endfunction

  // Sender: a new word goes out at the falling edge once the previous one
  // was taken. A stalled word stays on the ports untouched. Idling runs at
  // 14 percent in the first third of the stimulus, 73 in the second and
  // not at all in the last.
  always @(negedge clk) begin : sender
    scan_word_t w;
    int         idle_pct;
    idle_pct = (n_sent * 3 < n_words) ? 14 : (n_sent * 3 < n_words * 2) ? 73 : 0;
    if (rst_n && (!in_valid || in_taken)) begin
      if (words_pending.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        w = words_pending.pop_front();
        in_valid     <= 1'b1;
        in_action    <= w.action;
        in_seed_char <= w.seed;
        in_src_char  <= w.src;
        n_sent       <= n_sent + 1;
      end
    end
  end

  // Receiver: stalls at 73 percent, then 14, then never, mirroring the
  // sender. Once, three quarters of the way through, it holds off for a long
  // stretch so that the output and skid registers fill and in_stall rises
  // while the sender keeps offering.
  always @(negedge clk) begin : receiver
    int stall_pct;
    stall_pct = (n_sent * 3 < n_words) ? 73 : (n_sent * 3 < n_words * 2) ? 14 : 0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_sent * 4 >= n_words * 3) begin
      out_stall <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor and predictor at the rising edge. The result word handed over at
  // this edge belongs to an earlier input word, so it is checked before the
  // word accepted at this same edge adds its own expectation.
  always @(posedge clk) begin : monitor
    ses_result_t want;
    n_cycles <= n_cycles + 1;
    if (!rst_n) begin
      sc_open     = 1'b0;
      sc_quoted   = 1'b0;
      sc_quote_ch = 8'd0;
      sc_last_nb  = CH_NL;
      sc_depth    = '0;
      sc_len      = '0;
      in_taken   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          note_mismatch("result word with nothing expected", 1, 0);
        end else begin
          want = results_due.pop_front();
          if (out_keep_valid !== want.keep_valid)
            note_mismatch("keep_valid", out_keep_valid, want.keep_valid);
          if (out_kept_char !== want.kept_char)
            note_mismatch("kept_char", out_kept_char, want.kept_char);
          if (out_stmt_end !== want.stmt_end)
            note_mismatch("stmt_end", out_stmt_end, want.stmt_end);
          if (out_push_back !== want.push_back)
            note_mismatch("push_back", out_push_back, want.push_back);
          if (out_err_left_paren !== want.err_left_paren)
            note_mismatch("err_left_paren", out_err_left_paren, want.err_left_paren);
          if (out_err_too_long !== want.err_too_long)
            note_mismatch("err_too_long", out_err_too_long, want.err_too_long);
          if (out_err_right_paren !== want.err_right_paren)
            note_mismatch("err_right_paren", out_err_right_paren, want.err_right_paren);
        end
      end
      if (in_valid && !in_stall) begin
        results_due.push_back(scan_step({in_action, in_seed_char, in_src_char}));
        n_taken++;
      end
      in_taken <= in_valid && !in_stall;
    end
  end

  // Watchdog on the cycle count.
  initial begin
    while (n_cycles < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int         n_rand;
    int         len;
    logic       long_done;
    logic [7:0] c;

    // Directed words. A character before any begin is outside a statement
    // and must give an empty result.
    put_char("x");
    put_char(8'd0);
    // A closing paren balances the depth; the newline after it ends the statement.
    put_begin(CH_NL);
    put_char("a");
    put_char(CH_LPAREN);
    put_char(CH_RPAREN);
    put_char(CH_NL);
    // A newline after '=' continues; a stray ')' goes negative; a brace with
    // open parens ends, is pushed back and flags the unclosed depth.
    put_begin(CH_EQUAL);
    put_char(CH_NL);
    put_char(CH_RPAREN);
    put_char(CH_LPAREN);
    put_char(CH_LPAREN);
    put_char(CH_LBRACE);
    // Terminators inside double quotes are kept; the semicolon after the
    // closing quote ends the statement.
    put_begin(8'hFF);
    put_char(CH_DQUOTE);
    put_char(CH_SEMI);
    put_char(CH_NL);
    put_char(CH_RBRACE);
    put_char(CH_DQUOTE);
    put_char(CH_TAB);
    put_char(CH_SEMI);
    // A double quote does not close a single-quoted string. A newline after
    // an ordinary character ends the statement.
    put_begin(8'd0);
    put_char(CH_SQUOTE);
    put_char(CH_DQUOTE);
    put_char(CH_SQUOTE);
    put_char(8'hFF);
    put_char(CH_NL);
    // A begin in the middle of a statement abandons it.
    put_begin(CH_NL);
    put_char(CH_NL);
    put_begin(CH_LPAREN);
    put_char(CH_RBRACE);

    // Random statements with random content, a tenth of them replaced by
    // noise, until the stimulus holds about 900 words. One long statement
    // goes in along the way: its quoted text runs past the length limit with
    // no check, and the first character after the closing quote hits the limit.
    n_rand    = 0;
    long_done = 1'b0;
    while (words_pending.size() < 900) begin
      if (!long_done && n_rand >= 300) begin
        long_done = 1'b1;
        put_begin(8'($urandom_range(97, 122)));
        repeat (10) put_char(8'($urandom_range(97, 122)));
        put_char(CH_DQUOTE);
        repeat (LEN_LIMIT) begin
          c = 8'($urandom);
          if (c == CH_DQUOTE) c = CH_SQUOTE;
          put_char(c);
        end
        put_char(CH_DQUOTE);
        repeat (4) put_char(8'($urandom_range(97, 122)));
      end else if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 5);
        repeat (len) put_word(1'($urandom), 8'($urandom), 8'($urandom));
        n_rand += len;
      end else begin
        case ($urandom_range(0, 5))
          0:       put_begin(CH_NL);
          1, 2:    put_begin(pick_goes_on());
          3:       put_begin(8'($urandom));
          default: put_begin(8'($urandom_range(97, 122)));
        endcase
        len = $urandom_range(0, 30);
        repeat (len) put_char(pick_text_char());
        case ($urandom_range(0, 4))
          0:       put_char(CH_LBRACE);
          1:       put_char(CH_RBRACE);
          2:       put_char(CH_NL);
          default: put_char(CH_SEMI);
        endcase
        n_rand += len + 2;
      end
    end
    n_words = words_pending.size();

    // Synchronous reset, released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be accepted and every result word to arrive,
    // then wait out a drain period so that any stray output shows.
    while (n_taken != n_words || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      note_mismatch("result words never delivered", 0, results_due.size());

    if (n_bad == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
